>>> sv/tfrc_pkg.sv
// Shared types and constants for the tile flag rectangle collision unit.
// Holds the controller state type, the command and status structs and register codes.
// No dependencies.
package tfrc_pkg;

  localparam logic [1:0] CFG_ORIGIN_X   = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y   = 2'd1;
  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Reciprocal divider: shift amount, reciprocal width, magnitude and quotient widths; index width.
  localparam int DIV_K = 24;
  localparam int RCPW  = DIV_K + 1;
  localparam int MAGW  = 17;
  localparam int QW    = 19;
  localparam int IDXW  = 27;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_DIV_W1,
    ST_DIV_W2,
    ST_DIV_W3,
    ST_ROW,
    ST_COL,
    ST_WRITE,
    ST_DRAIN,
    ST_FINISH
  } tfrc_state_t;

  typedef struct packed {
    logic clr_en;
    logic load_item;
    logic div_go;
    logic div_y;
    logic cap_x;
    logic cap_y;
    logic row_load;
    logic row_adv;
    logic col_start;
    logic col_step;
    logic col_rd;
    logic wr_go;
    logic res_load;
  } tfrc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic row_ok;
    logic row_last;
    logic col_last;
    logic out_free;
  } tfrc_status_t;

endpackage

>>> sv/tfrc_ctrl.sv
// Controller state machine for the tile flag rectangle collision unit.
// Sequences the clearing pass, the divider, the row and column walk and the result.
// Depends on tfrc_pkg.
module tfrc_ctrl import tfrc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  tfrc_status_t st,
  output logic         in_stall,
  output tfrc_cmd_t    cmd
);

  tfrc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (st.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        cmd.div_go = 1'b1;
        state_next = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        cmd.div_go = 1'b1;
        cmd.div_y = 1'b1;
        state_next = ST_DIV_W1;
      end
      ST_DIV_W1: begin
        state_next = ST_DIV_W2;
      end
      ST_DIV_W2: begin
        cmd.cap_x = 1'b1;
        state_next = ST_DIV_W3;
      end
      ST_DIV_W3: begin
        cmd.cap_y = 1'b1;
        state_next = ST_ROW;
      end
      ST_ROW: begin
        cmd.row_load = 1'b1;
        if (!st.is_query) begin
          state_next = ST_WRITE;
        end else if (st.row_ok) begin
          cmd.col_start = 1'b1;
          state_next = ST_COL;
        end else if (st.row_last) begin
          state_next = ST_DRAIN;
        end else begin
          cmd.row_adv = 1'b1;
        end
      end
      ST_COL: begin
        cmd.col_rd = 1'b1;
        if (!st.col_last) begin
          cmd.col_step = 1'b1;
        end else if (st.row_last) begin
          state_next = ST_DRAIN;
        end else begin
          cmd.row_adv = 1'b1;
          state_next = ST_ROW;
        end
      end
      ST_WRITE: begin
        cmd.wr_go = 1'b1;
        state_next = ST_FINISH;
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.res_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> sv/tfrc_datapath.sv
// Datapath for the tile flag rectangle collision unit: configuration registers,
// reciprocal divider, tile coordinate trackers, flag memory and result register.
// Depends on tfrc_pkg; driven by tfrc_ctrl through tfrc_cmd_t.
module tfrc_datapath import tfrc_pkg::*; #(
  parameter int TILE_W    = 16,
  parameter int TILE_H    = 16,
  parameter int MAX_TILES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  tfrc_cmd_t          cmd,
  input  logic               action,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic        [7:0]  rect_width,
  input  logic        [7:0]  rect_height,
  input  logic        [7:0]  flag_value,
  input  logic               cfg_wr,
  input  logic        [1:0]  cfg_index,
  input  logic        [15:0] cfg_data,
  input  logic               out_stall,
  output logic               out_valid,
  output logic        [7:0]  hit_flags,
  output tfrc_status_t       st
);

  localparam int AW = $clog2(MAX_TILES);
  localparam logic [RCPW-1:0] RCP_X = RCPW'(((1 << DIV_K) + TILE_W - 1) / TILE_W);
  localparam logic [RCPW-1:0] RCP_Y = RCPW'(((1 << DIV_K) + TILE_H - 1) / TILE_H);
  localparam logic [6:0] TW = 7'(TILE_W);
  localparam logic [6:0] TH = 7'(TILE_H);
  localparam logic signed [IDXW-1:0] MAX_IDX = IDXW'(MAX_TILES);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_TILES - 1);

  logic signed [15:0] origin_x, origin_y;
  logic        [6:0]  map_width, map_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_y   <= '0;
      map_width  <= 7'd64;
      map_height <= 7'd64;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:   origin_x <= cfg_data;
        CFG_ORIGIN_Y:   origin_y <= cfg_data;
        CFG_MAP_WIDTH:  map_width <= cfg_data[6:0];
        CFG_MAP_HEIGHT: map_height <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic               it_action;
  logic signed [15:0] it_px, it_py;
  logic        [7:0]  it_w, it_h, it_flag;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_action <= action;
      it_px     <= point_x;
      it_py     <= point_y;
      it_w      <= rect_width;
      it_h      <= rect_height;
      it_flag   <= flag_value;
    end
  end

  logic [6:0] sx, sy;
  assign sx = (it_w < {1'b0, TW}) ? it_w[6:0] : TW;
  assign sy = (it_h < {1'b0, TH}) ? it_h[6:0] : TH;

  // Divider stage 1: offset from the origin and its magnitude.
  logic signed [17:0] dif, dif_neg;
  logic [MAGW-1:0] s1_mag;
  logic s1_neg, s1_y;

  assign dif = cmd.div_y
             ? ($signed({{2{it_py[15]}}, it_py}) - $signed({{2{origin_y[15]}}, origin_y}))
             : ($signed({{2{it_px[15]}}, it_px}) - $signed({{2{origin_x[15]}}, origin_x}));
  assign dif_neg = -dif;

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      s1_mag <= dif[17] ? dif_neg[MAGW-1:0] : dif[MAGW-1:0];
      s1_neg <= dif[17];
      s1_y   <= cmd.div_y;
    end
  end

  // Divider stage 2: multiplication by the reciprocal of the tile size.
  logic [MAGW+RCPW-1:0] prod;
  logic [MAGW-1:0] s2_q, s2_mag;
  logic s2_neg, s2_y;

  assign prod = {{RCPW{1'b0}}, s1_mag} * {{MAGW{1'b0}}, (s1_y ? RCP_Y : RCP_X)};

  always_ff @(posedge clk) begin
    s2_q   <= prod[DIV_K+MAGW-1:DIV_K];
    s2_mag <= s1_mag;
    s2_neg <= s1_neg;
    s2_y   <= s1_y;
  end

  // Divider stage 3: remainder and conversion to a floor quotient.
  logic [6:0] t_sel;
  logic [MAGW+6:0] tprod;
  logic [MAGW-1:0] rem_full;
  logic [6:0] rem_t;
  logic signed [QW-1:0] q_pos, q_flr;
  logic [6:0] r_flr;
  logic signed [QW-1:0] s3_q;
  logic [6:0] s3_r;

  assign t_sel    = s2_y ? TH : TW;
  assign tprod    = {7'd0, s2_q} * {{MAGW{1'b0}}, t_sel};
  assign rem_full = s2_mag - tprod[MAGW-1:0];
  assign rem_t    = rem_full[6:0];
  assign q_pos    = $signed({2'b00, s2_q});

  always_comb begin
    if (!s2_neg) begin
      q_flr = q_pos;
      r_flr = rem_t;
    end else if (rem_t != 7'd0) begin
      q_flr = -q_pos - QW'(1);
      r_flr = t_sel - rem_t;
    end else begin
      q_flr = -q_pos;
      r_flr = 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    s3_q <= q_flr;
    s3_r <= r_flr;
  end

  // Tile coordinate trackers: floor quotient and remainder, stepped by the sample pitch.
  logic signed [QW-1:0] xq0, xq, yq;
  logic [6:0] xr0, xr, yr;
  logic [8:0] xo, yo;
  logic [7:0] xsum, ysum;
  logic signed [QW-1:0] col_t, row_t;

  assign xsum = {1'b0, xr} + {1'b0, sx};
  assign ysum = {1'b0, yr} + {1'b0, sy};

  always_ff @(posedge clk) begin
    if (cmd.cap_x) begin
      xq0 <= s3_q;
      xr0 <= s3_r;
      xq  <= s3_q;
      xr  <= s3_r;
      xo  <= '0;
    end else if (cmd.col_start) begin
      xq <= xq0;
      xr <= xr0;
      xo <= '0;
    end else if (cmd.col_step) begin
      xo <= xo + {2'b00, sx};
      if (xsum >= {1'b0, TW}) begin
        xr <= 7'(xsum - {1'b0, TW});
        xq <= xq + QW'(1);
      end else begin
        xr <= xsum[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_y) begin
      yq <= s3_q;
      yr <= s3_r;
      yo <= '0;
    end else if (cmd.row_adv) begin
      yo <= yo + {2'b00, sy};
      if (ysum >= {1'b0, TH}) begin
        yr <= 7'(ysum - {1'b0, TH});
        yq <= yq + QW'(1);
      end else begin
        yr <= ysum[6:0];
      end
    end
  end

  assign col_t = xq + $signed({{(QW-1){1'b0}}, (xq[QW-1] && xr != 7'd0)});
  assign row_t = yq + $signed({{(QW-1){1'b0}}, (yq[QW-1] && yr != 7'd0)});

  logic [9:0] xo_nx, yo_nx;
  assign xo_nx = {1'b0, xo} + {3'b000, sx};
  assign yo_nx = {1'b0, yo} + {3'b000, sy};

  logic signed [QW-1:0] mw_q, mh_q;
  assign mw_q = $signed({{(QW-7){1'b0}}, map_width});
  assign mh_q = $signed({{(QW-7){1'b0}}, map_height});

  // Linear index of the current tile.
  logic signed [IDXW-1:0] row_base, idx, area_e;
  logic [13:0] area;
  logic col_ok, wr_fire;

  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      row_base <= $signed({{(IDXW-QW){row_t[QW-1]}}, row_t})
                * $signed({{(IDXW-7){1'b0}}, map_width});
    end
  end

  assign idx    = row_base + $signed({{(IDXW-QW){col_t[QW-1]}}, col_t});
  assign area   = {7'd0, map_width} * {7'd0, map_height};
  assign area_e = $signed({{(IDXW-14){1'b0}}, area});
  assign col_ok = !col_t[QW-1] && (col_t < mw_q) && (idx < MAX_IDX);
  assign wr_fire = cmd.wr_go && !idx[IDXW-1] && (idx < area_e) && (idx < MAX_IDX);

  // Flag memory and clearing pass.
  logic [7:0] mem [MAX_TILES];
  logic [AW-1:0] clr_cnt;
  logic [7:0] rd_data;
  logic rd_vld;
  logic [7:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_cnt] <= 8'd0;
    end else if (wr_fire) begin
      mem[idx[AW-1:0]] <= it_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.col_rd) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.col_rd && col_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      acc <= 8'd0;
    end else if (rd_vld) begin
      acc <= acc | rd_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      hit_flags <= (it_action == ACT_QUERY) ? acc : 8'd0;
    end
  end

  assign st.clr_last = (clr_cnt == CLR_LAST);
  assign st.is_query = (it_action == ACT_QUERY);
  assign st.row_ok   = !row_t[QW-1] && (row_t < mh_q);
  assign st.row_last = (it_h == 8'd0) || (yo_nx > {2'b00, it_h});
  assign st.col_last = (it_w == 8'd0) || (xo_nx > {2'b00, it_w});
  assign st.out_free = !out_valid || !out_stall;

endmodule

>>> sv/tile_flag_rect_collision_unit.sv
// Top level of the tile flag rectangle collision unit: controller plus datapath.
// A write passes through the divider states, the row load and the write; a query walks,
// per sampled row, the row load and, when the row is in the map, one read per sampled column.
// One request at a time: the next is taken once the result loads into the output register,
// which waits while the output stalls.
// Synchronous reset; then a clearing pass over all MAX_TILES flag memory entries.
module tile_flag_rect_collision_unit import tfrc_pkg::*; #(
  parameter int TILE_W    = 16,
  parameter int TILE_H    = 16,
  parameter int MAX_TILES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic        [7:0]  rect_width,
  input  logic        [7:0]  rect_height,
  input  logic        [7:0]  flag_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [7:0]  hit_flags,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [1:0]  cfg_index,
  input  logic        [15:0] cfg_data
);

  tfrc_cmd_t    cmd;
  tfrc_status_t st;

  assign cfg_ready = 1'b1;

  tfrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  tfrc_datapath #(
    .TILE_W    (TILE_W),
    .TILE_H    (TILE_H),
    .MAX_TILES (MAX_TILES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .action      (action),
    .point_x     (point_x),
    .point_y     (point_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .flag_value  (flag_value),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .hit_flags   (hit_flags),
    .st          (st)
  );

endmodule

>>> test/tile_flag_rect_collision_unit_test.sv
// Self-checking testbench for tile_flag_rect_collision_unit: directed table, then random phases.
// Predicts hit_flags from its flag store and map, or from the table, under random idling.
// Depends on tfrc_pkg and the tile_flag_rect_collision_unit RTL.
module tile_flag_rect_collision_unit_test import tfrc_pkg::*;;

  localparam int TILE_W          = 16;
  localparam int TILE_H          = 16;
  localparam int MAX_TILES       = 4096;
  localparam int NUM_DIRECTED    = 22;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 20000;

  typedef struct packed {
    logic               act;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic        [7:0]  w;
    logic        [7:0]  h;
    logic        [7:0]  flag;
    logic               chk;
    logic        [7:0]  hit;
  } tile_req_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               action = ACT_WRITE;
  logic signed [15:0] point_x = '0;
  logic signed [15:0] point_y = '0;
  logic        [7:0]  rect_width = '0;
  logic        [7:0]  rect_height = '0;
  logic        [7:0]  flag_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic        [7:0]  hit_flags;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [1:0]  cfg_index = CFG_ORIGIN_X;
  logic        [15:0] cfg_data = '0;

  logic [7:0] flag_mem [MAX_TILES];
  int         org_x = 0;
  int         org_y = 0;
  int         map_w = 64;
  int         map_h = 64;
  logic [7:0] hits_due [$];
  int         errors = 0;
  int         sender_idle_pct = 0;
  int         receiver_idle_pct = 0;
  logic       hold_request = 1'b0;
  int         hold_left = 0;
  int         quiet_cycles = 0;

  tile_req_t directed_reqs [NUM_DIRECTED] = '{
    '{ACT_QUERY, 16'sd0, 16'sd0, 8'd255, 8'd255, 8'h00, 1'b1, 8'h00},
    '{ACT_WRITE, 16'sd0, 16'sd0, 8'd0, 8'd0, 8'hff, 1'b1, 8'h00},
    '{ACT_QUERY, 16'sd0, 16'sd0, 8'd0, 8'd0, 8'h00, 1'b1, 8'hff},
    '{ACT_WRITE, 16'h8000, 16'h8000, 8'd255, 8'd255, 8'h01, 1'b1, 8'h00},
    '{ACT_WRITE, 16'h7fff, 16'h7fff, 8'd0, 8'd0, 8'h02, 1'b1, 8'h00},
    '{ACT_WRITE, 16'sd1023, 16'sd1023, 8'd0, 8'd0, 8'h80, 1'b1, 8'h00},
    '{ACT_QUERY, 16'sd1008, 16'sd1008, 8'd0, 8'd0, 8'h00, 1'b1, 8'h80},
    '{ACT_WRITE, 16'sd1024, 16'sd0, 8'd0, 8'd0, 8'h04, 1'b1, 8'h00},
    '{ACT_QUERY, 16'sd0, 16'sd16, 8'd0, 8'd0, 8'h00, 1'b1, 8'h04},
    '{ACT_QUERY, -16'sd15, -16'sd15, 8'd0, 8'd0, 8'h00, 1'b1, 8'hff},
    '{ACT_QUERY, 16'h8000, 16'h8000, 8'd255, 8'd255, 8'h00, 1'b1, 8'h00},
    '{ACT_QUERY, 16'h7fff, 16'h7fff, 8'd255, 8'd255, 8'h00, 1'b1, 8'h00},
    '{ACT_QUERY, -16'sd16, -16'sd16, 8'd16, 8'd16, 8'h00, 1'b0, 8'h00},
    '{ACT_WRITE, 16'sd40, 16'sd0, 8'd0, 8'd0, 8'h10, 1'b1, 8'h00},
    '{ACT_QUERY, 16'sd0, 16'sd0, 8'd40, 8'd0, 8'h00, 1'b0, 8'h00},
    '{ACT_QUERY, 16'sd1, 16'sd0, 8'd15, 8'd0, 8'h00, 1'b0, 8'h00},
    '{ACT_QUERY, 16'sd0, 16'sd0, 8'd255, 8'd255, 8'h00, 1'b0, 8'h00},
    '{ACT_WRITE, 16'sd0, 16'sd0, 8'd0, 8'd0, 8'h00, 1'b1, 8'h00},
    '{ACT_QUERY, 16'sd0, 16'sd0, 8'd0, 8'd0, 8'h00, 1'b1, 8'h00},
    '{ACT_QUERY, 16'sd1000, 16'sd1000, 8'd255, 8'd255, 8'h00, 1'b0, 8'h00},
    '{ACT_WRITE, 16'sd1, 16'sd1, 8'd255, 8'd255, 8'h55, 1'b1, 8'h00},
    '{ACT_QUERY, 16'sd0, 16'sd0, 8'h80, 8'h01, 8'h00, 1'b0, 8'h00}
  };

  tile_flag_rect_collision_unit #(
    .TILE_W   (TILE_W),
    .TILE_H   (TILE_H),
    .MAX_TILES(MAX_TILES)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .point_x    (point_x),
    .point_y    (point_y),
    .rect_width (rect_width),
    .rect_height(rect_height),
    .flag_value (flag_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit_flags  (hit_flags),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (flag_mem[k]) flag_mem[k] = 8'h00;
  end

  function automatic void store_tile_flag(logic signed [15:0] px, logic signed [15:0] py,
                                          logic [7:0] flag);
    int col;
    int row;
    int idx;
    col = (int'(px) - org_x) / TILE_W;
    row = (int'(py) - org_y) / TILE_H;
    idx = row * map_w + col;
    if (idx < 0 || idx >= map_w * map_h || idx >= MAX_TILES) return;
    flag_mem[idx] = flag;
  endfunction

  function automatic logic [7:0] tile_hit_or(logic signed [15:0] px, logic signed [15:0] py,
                                             logic [7:0] w, logic [7:0] h);
    int wi;
    int hi;
    int sx;
    int sy;
    int nx;
    int ny;
    int row;
    int col;
    int idx;
    logic [7:0] acc;
    wi = w;
    hi = h;
    sx = (wi < TILE_W) ? wi : TILE_W;
    sy = (hi < TILE_H) ? hi : TILE_H;
    nx = (wi == 0) ? 1 : wi / sx + 1;
    ny = (hi == 0) ? 1 : hi / sy + 1;
    acc = 8'h00;
    for (int j = 0; j < ny; j++) begin
      row = (int'(py) + j * sy - org_y) / TILE_H;
      if (row < 0 || row >= map_h) continue;
      for (int i = 0; i < nx; i++) begin
        col = (int'(px) + i * sx - org_x) / TILE_W;
        if (col < 0 || col >= map_w) continue;
        idx = row * map_w + col;
        if (idx >= MAX_TILES) continue;
        acc |= flag_mem[idx];
      end
    end
    return acc;
  endfunction

  function automatic tile_req_t random_request();
    tile_req_t r;
    int span_x;
    int span_y;
    r = '0;
    r.act = ($urandom_range(99) < 40) ? ACT_WRITE : ACT_QUERY;
    if ($urandom_range(99) < 85) begin
      span_x = map_w * TILE_W + 128;
      span_y = map_h * TILE_H + 128;
      r.px = 16'(org_x - 64 + int'($urandom_range(span_x)));
      r.py = 16'(org_y - 64 + int'($urandom_range(span_y)));
    end else begin
      r.px = 16'($urandom);
      r.py = 16'($urandom);
    end
    case ($urandom_range(9))
      0, 1:    begin r.w = 8'($urandom); r.h = 8'($urandom); end
      2:       begin r.w = 8'd0; r.h = 8'($urandom_range(40)); end
      3:       begin r.w = 8'($urandom_range(40)); r.h = 8'd0; end
      default: begin r.w = 8'($urandom_range(40)); r.h = 8'($urandom_range(40)); end
    endcase
    case ($urandom_range(9))
      0:          r.flag = 8'h00;
      1, 2, 3, 4: r.flag = 8'h01 << $urandom_range(7);
      default:    r.flag = 8'($urandom);
    endcase
    return r;
  endfunction

  task automatic send_request(tile_req_t r);
    logic [7:0] hit;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= r.act;
    point_x     <= r.px;
    point_y     <= r.py;
    rect_width  <= r.w;
    rect_height <= r.h;
    flag_value  <= r.flag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.act == ACT_WRITE) begin
      store_tile_flag(r.px, r.py, r.flag);
      hit = 8'h00;
    end else begin
      hit = tile_hit_or(r.px, r.py, r.w, r.h);
    end
    if (r.chk) hit = r.hit;
    hits_due.push_back(hit);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ORIGIN_X:   org_x = int'(signed'(val));
      CFG_ORIGIN_Y:   org_y = int'(signed'(val));
      CFG_MAP_WIDTH:  map_w = int'(val[6:0]);
      CFG_MAP_HEIGHT: map_h = int'(val[6:0]);
      default: ;
    endcase
  endtask

  task automatic load_map_config(logic [15:0] ox, logic [15:0] oy, int mw, int mh);
    logic [15:0] wv;
    logic [15:0] hv;
    wv = 16'($urandom);
    hv = 16'($urandom);
    wv[6:0] = 7'(mw);
    hv[6:0] = 7'(mh);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_MAP_WIDTH, wv);
    write_reg(CFG_MAP_HEIGHT, hv);
    cfg_valid <= 1'b0;
  endtask

  // Result checker and receiver-side stall generation.
  always @(posedge clk) begin
    logic [7:0] exp_hit;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (hits_due.size() == 0) begin
          $display("%0t: unexpected result, hit_flags actual %h", $time, hit_flags);
          errors++;
        end else begin
          exp_hit = hits_due.pop_front();
          if (hit_flags !== exp_hit) begin
            $display("%0t: hit_flags expected %h actual %h", $time, exp_hit, hit_flags);
            errors++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [15:0] ox;
    logic [15:0] oy;
    int mw;
    int mh;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct   = 18;
    receiver_idle_pct = 66;
    for (int n = 0; n < NUM_DIRECTED; n++) send_request(directed_reqs[n]);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid <= 1'b0;
      while (hits_due.size() != 0) @(posedge clk);
      case (ph)
        0: begin ox = 16'sd0; oy = 16'sd0; mw = 64; mh = 64; end
        1: begin ox = 16'h8000; oy = 16'h7fff; mw = 1; mh = 1; end
        2: begin ox = 16'h7fff; oy = 16'h8000; mw = 64; mh = 1; end
        3: begin ox = 16'sd123; oy = -16'sd77; mw = 0; mh = 9; end
        4: begin ox = -16'sd500; oy = 16'sd40; mw = 127; mh = 127; end
        5: begin
          ox = 16'($urandom);
          oy = 16'($urandom_range(2000)) - 16'sd1000;
          mw = $urandom_range(1, 64);
          mh = $urandom_range(1, 64);
        end
        6: begin ox = -16'sd1; oy = -16'sd1; mw = 7; mh = 0; end
        default: begin
          ox = 16'($urandom);
          oy = 16'($urandom);
          mw = $urandom_range(1, 64);
          mh = 64;
        end
      endcase
      load_map_config(ox, oy, mw, mh);
      if (ph < 3) begin
        sender_idle_pct   = 18;
        receiver_idle_pct = 66;
      end else if (ph < 6) begin
        sender_idle_pct   = 66;
        receiver_idle_pct = 18;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      if (ph == 1 || ph == 6) hold_request = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(random_request());
    end
    in_valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && hits_due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
